### rtl/appt_pkg.sv
// Package for the arm pose point transform: widths, CORDIC constants and
// the arctangent table. No dependencies.
package appt_pkg;

    localparam int ANGLE_BITS_DEF   = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_ENTRIES     = 24;
    localparam int COORD_W          = 32;
    localparam int LEN_W            = 31;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 32;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_YAW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUTER  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_Z = 3'd6;

    localparam logic signed [33:0] CORDIC_START = 34'sd652032874;

    // Arctangent of 2^-i in units of 2^-32 turn.
    function automatic logic signed [33:0] atan_turn(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        atan_turn = $signed({2'b00, v});
    endfunction

endpackage

### rtl/appt_if.sv
// Valid/ready channel interfaces for points and configuration writes.
// Depends on appt_pkg.
interface appt_point_if;
    logic valid;
    logic ready;
    logic signed [appt_pkg::COORD_W-1:0] x;
    logic signed [appt_pkg::COORD_W-1:0] y;
    logic signed [appt_pkg::COORD_W-1:0] z;
    modport source (output valid, x, y, z, input ready);
    modport sink   (input valid, x, y, z, output ready);
endinterface

interface appt_world_if;
    logic valid;
    logic ready;
    logic signed [appt_pkg::COORD_W-1:0] world_x;
    logic signed [appt_pkg::COORD_W-1:0] world_y;
    logic signed [appt_pkg::COORD_W-1:0] world_z;
    logic saturated;
    modport source (output valid, world_x, world_y, world_z, saturated, input ready);
    modport sink   (input valid, world_x, world_y, world_z, saturated, output ready);
endinterface

interface appt_cfg_if;
    logic valid;
    logic ready;
    logic [appt_pkg::CFG_IDX_W-1:0]  index;
    logic [appt_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/arm_pose_point_transform.sv
// Arm pose point transform: world = R(yaw, pitch) * local + t.
// Throughput one item per cycle, set by the fully pipelined CORDIC and
// multiplier stages. A stall freezes the pipe. Reset (rst_n, asynchronous,
// active low) clears the configuration registers and the valid bits, which
// empties the pipeline. Depends on appt_pkg and the interfaces in appt_if.
module arm_pose_point_transform #(
    parameter int ANGLE_BITS   = appt_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = appt_pkg::CORDIC_STEPS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    appt_cfg_if.sink    cfg,
    appt_point_if.sink  in_pt,
    appt_world_if.source out_pt
);
    localparam int N   = (CORDIC_STEPS < appt_pkg::ATAN_ENTRIES) ?
                         CORDIC_STEPS : appt_pkg::ATAN_ENTRIES;
    localparam int LAT = N + 6;

    logic [ANGLE_BITS-1:0]      yaw_reg, pitch_reg;
    logic [appt_pkg::LEN_W-1:0] outer_reg, column_reg;
    logic signed [31:0]         bx_reg, by_reg, bz_reg;

    // Configuration registers.
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            yaw_reg <= '0; pitch_reg <= '0; outer_reg <= '0; column_reg <= '0;
            bx_reg <= '0; by_reg <= '0; bz_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                appt_pkg::REG_YAW:    yaw_reg    <= cfg.data[ANGLE_BITS-1:0];
                appt_pkg::REG_PITCH:  pitch_reg  <= cfg.data[ANGLE_BITS-1:0];
                appt_pkg::REG_OUTER:  outer_reg  <= cfg.data[appt_pkg::LEN_W-1:0];
                appt_pkg::REG_COLUMN: column_reg <= cfg.data[appt_pkg::LEN_W-1:0];
                appt_pkg::REG_BASE_X: bx_reg     <= cfg.data;
                appt_pkg::REG_BASE_Y: by_reg     <= cfg.data;
                appt_pkg::REG_BASE_Z: bz_reg     <= cfg.data;
                default: ;
            endcase
        end
    end

    // Pipeline advances whenever the output stage is empty or being taken.
    logic en;
    logic [LAT-1:0] v_reg;
    assign en          = !v_reg[LAT-1] || out_pt.ready;
    assign in_pt.ready = en;
    assign out_pt.valid = v_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[LAT-2:0], in_pt.valid};
    end

    // Point delay line alongside the CORDIC and the matrix stages.
    logic signed [31:0] px_reg [0:N+2];
    logic signed [31:0] py_reg [0:N+2];
    logic signed [31:0] pz_reg [0:N+2];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg[0] <= in_pt.x; py_reg[0] <= in_pt.y; pz_reg[0] <= in_pt.z;
            for (int k = 1; k <= N + 2; k++)
            begin
                px_reg[k] <= px_reg[k-1];
                py_reg[k] <= py_reg[k-1];
                pz_reg[k] <= pz_reg[k-1];
            end
        end
    end

    logic signed [33:0] c0, s0, c1, s1;
    appt_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_yaw (
        .clk(clk), .en(en), .angle(yaw_reg),
        .cos_out(c0), .sin_out(s0));
    appt_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_pitch (
        .clk(clk), .en(en), .angle(pitch_reg),
        .cos_out(c1), .sin_out(s1));

    // Rounded Q30 product, floor shift.
    function automatic logic signed [37:0] mul30(input logic signed [33:0] a,
                                                 input logic signed [33:0] b);
        logic signed [67:0] p;
        p = a * b + 68'sd536870912;
        mul30 = p[67:30];
    endfunction

    // Stage A: register sines and cosines.
    logic signed [33:0] c0_reg, s0_reg, c1_reg, s1_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c0_reg <= c0; s0_reg <= s0; c1_reg <= c1; s1_reg <= s1;
        end
    end

    // Stage B: matrix entries.
    logic signed [33:0] m00_reg, m02_reg, m10_reg, m12_reg, ns0_reg, c0b_reg;
    logic signed [33:0] s1b_reg, c1b_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m00_reg <= 34'(mul30(c0_reg, c1_reg));
            m02_reg <= 34'(-mul30(c0_reg, s1_reg));
            m10_reg <= 34'(mul30(s0_reg, c1_reg));
            m12_reg <= 34'(-mul30(s0_reg, s1_reg));
            ns0_reg <= -s0_reg;
            c0b_reg <= c0_reg;
            s1b_reg <= s1_reg;
            c1b_reg <= c1_reg;
        end
    end

    // Stage C: the eleven products.
    logic signed [37:0] t_reg [0:10];
    logic signed [33:0] lx, ly, lz, l1;
    assign lx = 34'(px_reg[N+2]);
    assign ly = 34'(py_reg[N+2]);
    assign lz = 34'(pz_reg[N+2]);
    assign l1 = {3'b000, outer_reg};
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg[0]  <= mul30(m00_reg, lx);
            t_reg[1]  <= mul30(ns0_reg, ly);
            t_reg[2]  <= mul30(m02_reg, lz);
            t_reg[3]  <= mul30(m00_reg, l1);
            t_reg[4]  <= mul30(m10_reg, lx);
            t_reg[5]  <= mul30(c0b_reg, ly);
            t_reg[6]  <= mul30(m12_reg, lz);
            t_reg[7]  <= mul30(m10_reg, l1);
            t_reg[8]  <= mul30(s1b_reg, lx);
            t_reg[9]  <= mul30(c1b_reg, lz);
            t_reg[10] <= mul30(s1b_reg, l1);
        end
    end

    // Stage D: sums.
    logic signed [39:0] wx_reg, wy_reg, wz_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wx_reg <= 40'(t_reg[0]) + 40'(t_reg[1]) + 40'(t_reg[2]) + 40'(t_reg[3])
                    + 40'(bx_reg);
            wy_reg <= 40'(t_reg[4]) + 40'(t_reg[5]) + 40'(t_reg[6]) + 40'(t_reg[7])
                    + 40'(by_reg);
            wz_reg <= 40'(t_reg[8]) + 40'(t_reg[9]) + 40'(t_reg[10])
                    + $signed({9'd0, column_reg}) + 40'(bz_reg);
        end
    end

    // Stage E: saturation into the output register.
    function automatic logic [32:0] sat(input logic signed [39:0] v);
        if (v > 40'sd2147483647)
            sat = {1'b1, 32'h7FFFFFFF};
        else if (v < -40'sd2147483648)
            sat = {1'b1, 32'h80000000};
        else
            sat = {1'b0, v[31:0]};
    endfunction

    logic [32:0] sx, sy, sz;
    assign sx = sat(wx_reg);
    assign sy = sat(wy_reg);
    assign sz = sat(wz_reg);
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_pt.world_x   <= sx[31:0];
            out_pt.world_y   <= sy[31:0];
            out_pt.world_z   <= sz[31:0];
            out_pt.saturated <= sx[32] | sy[32] | sz[32];
        end
    end
endmodule

### rtl/appt_cordic.sv
// Pipelined rotation-mode CORDIC giving cosine and sine in Q2.30.
// Depends on appt_pkg. One step per stage, advanced by a shared enable.
module appt_cordic #(
    parameter int ANGLE_BITS   = appt_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = appt_pkg::CORDIC_STEPS_DEF
) (
    input  logic                   clk,
    input  logic                   en,
    input  logic [ANGLE_BITS-1:0]  angle,
    output logic signed [33:0]     cos_out,
    output logic signed [33:0]     sin_out
);
    localparam int N = (CORDIC_STEPS < appt_pkg::ATAN_ENTRIES) ?
                       CORDIC_STEPS : appt_pkg::ATAN_ENTRIES;

    logic signed [33:0] x_reg [0:N];
    logic signed [33:0] y_reg [0:N];
    logic signed [33:0] z_reg [0:N];
    logic               flip_reg [0:N];

    logic [31:0]        a32;
    logic signed [33:0] z0;
    logic               fl;

    // Widen the angle and fold it into the quarter turn around zero.
    always_comb
    begin
        a32 = {angle, {(32-ANGLE_BITS){1'b0}}};
        z0  = {{2{a32[31]}}, a32};
        fl  = (z0 > 34'sd1073741824) || (z0 < -34'sd1073741824);
        if (fl)
        begin
            z0 = z0 - 34'sd2147483648;
            if (z0 < -34'sd2147483648)
                z0 = z0 + 34'sd4294967296;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= appt_pkg::CORDIC_START;
            y_reg[0]    <= '0;
            z_reg[0]    <= z0;
            flip_reg[0] <= fl;
        end
    end

    // One micro-rotation per stage.
    for (genvar i = 0; i < N; i++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                flip_reg[i+1] <= flip_reg[i];
                if (z_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - appt_pkg::atan_turn(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + appt_pkg::atan_turn(i);
                end
            end
        end
    end

    assign cos_out = flip_reg[N] ? -x_reg[N] : x_reg[N];
    assign sin_out = flip_reg[N] ? -y_reg[N] : y_reg[N];
endmodule

### test/tb.sv
// Testbench for arm_pose_point_transform: drives camera-frame points and
// register writes, predicts world-frame points and checks every result.
// Depends on appt_pkg and the channel interfaces in appt_if.
module tb;
    localparam int ABITS = appt_pkg::ANGLE_BITS_DEF;
    localparam int STEPS = appt_pkg::CORDIC_STEPS_DEF;
    localparam int LATENCY = STEPS + 6;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_POINTS = 1050;
    localparam logic [2:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic signed [31:0] wx;
        logic signed [31:0] wy;
        logic signed [31:0] wz;
        logic sat;
    } world_pt_t;

    typedef struct {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        bit typed;
        world_pt_t want;
    } point_row_t;

    logic clk;
    logic rst_n;
    appt_cfg_if cfg_ch();
    appt_point_if pt_ch();
    appt_world_if world_ch();

    arm_pose_point_transform i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch.sink),
        .in_pt  (pt_ch.sink),
        .out_pt (world_ch.source)
    );

    // Register copy used by the predictor.
    logic [ABITS-1:0] yaw_q, pitch_q;
    logic [30:0] outer_q, column_q;
    logic signed [31:0] bx_q, by_q, bz_q;

    world_pt_t expected_points[$];
    int errors;
    int idle_cycles;
    bit steady;   // when set, no random idling on either side
    point_row_t directed_rows[$];

    // Clock.
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Arithmetic shift toward minus infinity.
    function automatic longint floor_shift(longint v, int s);
        floor_shift = v >>> s;
    endfunction

    function automatic longint fix_mul(longint a, longint b);
        fix_mul = (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    // Sine and cosine of an angle in Q2.30 by rotation-mode CORDIC.
    task automatic cordic_sin_cos(input logic [ABITS-1:0] ang, output longint c,
                                  output longint s);
        longint z, x, y, dx, dy;
        bit flip;
        z = longint'($signed({ang, {(32-ABITS){1'b0}}}));
        flip = 0;
        x = 652032874;
        y = 0;
        if (z > (64'sd1 <<< 30) || z < -(64'sd1 <<< 30))
        begin
            z -= 64'sd1 <<< 31;
            if (z < -(64'sd1 <<< 31))
                z += 64'sd1 <<< 32;
            flip = 1;
        end
        for (int i = 0; i < STEPS && i < appt_pkg::ATAN_ENTRIES; i++)
        begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= longint'(appt_pkg::atan_turn(i));
            end
            else
            begin
                x += dx; y -= dy; z += longint'(appt_pkg::atan_turn(i));
            end
        end
        if (flip)
        begin
            x = -x; y = -y;
        end
        c = x;
        s = y;
    endtask

    function automatic logic signed [31:0] clip32(longint v, ref logic hit);
        if (v > 64'sd2147483647)
        begin
            hit = 1'b1; return 32'sh7FFFFFFF;
        end
        if (v < -64'sd2147483648)
        begin
            hit = 1'b1; return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // World-frame point for a camera-frame point under the current pose.
    task automatic transform_point(input logic signed [31:0] lx,
                                   input logic signed [31:0] ly,
                                   input logic signed [31:0] lz,
                                   output world_pt_t r);
        longint c0, s0, c1, s1, m00, m02, m10, m12, x, y, z, l1;
        logic hit;
        cordic_sin_cos(yaw_q, c0, s0);
        cordic_sin_cos(pitch_q, c1, s1);
        l1 = longint'(outer_q);
        m00 = fix_mul(c0, c1);
        m02 = -fix_mul(c0, s1);
        m10 = fix_mul(s0, c1);
        m12 = -fix_mul(s0, s1);
        x = fix_mul(m00, lx) + fix_mul(-s0, ly) + fix_mul(m02, lz)
            + fix_mul(m00, l1) + longint'(bx_q);
        y = fix_mul(m10, lx) + fix_mul(c0, ly) + fix_mul(m12, lz)
            + fix_mul(m10, l1) + longint'(by_q);
        z = fix_mul(s1, lx) + fix_mul(c1, lz) + fix_mul(s1, l1)
            + longint'(column_q) + longint'(bz_q);
        hit = 1'b0;
        r.wx = clip32(x, hit);
        r.wy = clip32(y, hit);
        r.wz = clip32(z, hit);
        r.sat = hit;
    endtask

    function automatic bit idle_now();
        return !steady && ($urandom_range(99) < 35);
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return 32'h7FFFFFFF - $urandom_range(3);
            1: return 32'h80000000 + $urandom_range(3);
            2: return $urandom_range(32'h7FFFF) - 32'h3FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Write one register; the shadow copy keeps the low bits like the block.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            appt_pkg::REG_YAW:    yaw_q = val[ABITS-1:0];
            appt_pkg::REG_PITCH:  pitch_q = val[ABITS-1:0];
            appt_pkg::REG_OUTER:  outer_q = val[30:0];
            appt_pkg::REG_COLUMN: column_q = val[30:0];
            appt_pkg::REG_BASE_X: bx_q = val;
            appt_pkg::REG_BASE_Y: by_q = val;
            appt_pkg::REG_BASE_Z: bz_q = val;
            default: ;
        endcase
    endtask

    // Wait for the pipeline to drain before touching registers.
    task automatic drain();
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // Send one point, with random idle cycles before it.
    task automatic send_point(input logic [31:0] px, input logic [31:0] py,
                              input logic [31:0] pz, input bit typed,
                              input world_pt_t want);
        world_pt_t r;
        while (idle_now())
        begin
            pt_ch.valid <= 1'b0;
            @(posedge clk);
        end
        transform_point(px, py, pz, r);
        if (typed && r !== want)
        begin
            $display("%0t predictor disagrees with table: expected %h actual %h",
                     $time, want, r);
            errors++;
        end
        expected_points = {expected_points, (typed ? want : r)};
        pt_ch.valid <= 1'b1;
        pt_ch.x <= px;
        pt_ch.y <= py;
        pt_ch.z <= pz;
        do @(posedge clk); while (!pt_ch.ready);
    endtask

    // Sink side: random stalls and comparison against the oldest expectation.
    always @(posedge clk)
    begin
        world_pt_t got, want;
        if (rst_n)
        begin
            if (world_ch.valid && world_ch.ready)
            begin
                got = '{world_ch.world_x, world_ch.world_y, world_ch.world_z,
                        world_ch.saturated};
                if (expected_points.size() == 0)
                begin
                    $display("%0t unexpected result: expected none actual %h",
                             $time, got);
                    errors++;
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (got.wx !== want.wx)
                    begin
                        $display("%0t world_x: expected %h actual %h", $time, want.wx, got.wx);
                        errors++;
                    end
                    if (got.wy !== want.wy)
                    begin
                        $display("%0t world_y: expected %h actual %h", $time, want.wy, got.wy);
                        errors++;
                    end
                    if (got.wz !== want.wz)
                    begin
                        $display("%0t world_z: expected %h actual %h", $time, want.wz, got.wz);
                        errors++;
                    end
                    if (got.sat !== want.sat)
                    begin
                        $display("%0t saturated: expected %b actual %b",
                                 $time, want.sat, got.sat);
                        errors++;
                    end
                end
            end
            world_ch.ready <= !idle_now();
        end
    end

    // Watchdog on cycles with no accepted item on any channel.
    always @(posedge clk)
    begin
        if ((pt_ch.valid && pt_ch.ready) || (world_ch.valid && world_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic random_pose();
        write_reg(appt_pkg::REG_YAW, $urandom);
        write_reg(appt_pkg::REG_PITCH, $urandom);
        write_reg(appt_pkg::REG_OUTER,
                  ($urandom_range(1)) ? $urandom : $urandom_range(32'h3FFFFF));
        write_reg(appt_pkg::REG_COLUMN,
                  ($urandom_range(1)) ? $urandom : $urandom_range(32'h3FFFFF));
        write_reg(appt_pkg::REG_BASE_X, rand_coord());
        write_reg(appt_pkg::REG_BASE_Y, rand_coord());
        write_reg(appt_pkg::REG_BASE_Z, rand_coord());
    endtask

    // Directed table rows: zero pose is identity, so results read off directly.
    function automatic point_row_t row(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                        bit typed, world_pt_t want);
        point_row_t r;
        r.px = px; r.py = py; r.pz = pz; r.typed = typed; r.want = want;
        return r;
    endfunction

    initial
    begin
        world_pt_t none;
        none = '0;
        errors = 0;
        idle_cycles = 0;
        steady = 1'b0;
        yaw_q = '0; pitch_q = '0; outer_q = '0; column_q = '0;
        bx_q = '0; by_q = '0; bz_q = '0;
        rst_n = 1'b0;
        cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
        pt_ch.valid = 1'b0; pt_ch.x = '0; pt_ch.y = '0; pt_ch.z = '0;
        world_ch.ready = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed points under the reset pose and then under extreme poses.
        directed_rows = {directed_rows, row(0, 0, 0, 1, '{0, 0, 0, 0})};
        directed_rows = {directed_rows,
                         row(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, none)};
        directed_rows = {directed_rows,
                         row(32'h80000000, 32'h80000000, 32'h80000000, 0, none)};
        directed_rows = {directed_rows,
                         row(32'h00010000, 32'hFFFF0000, 32'h00000001, 0, none)};
        directed_rows = {directed_rows,
                         row(32'hFFFFFFFF, 32'h00000001, 32'hFFFFFFFF, 0, none)};
        foreach (directed_rows[i])
            send_point(directed_rows[i].px, directed_rows[i].py, directed_rows[i].pz,
                       directed_rows[i].typed, directed_rows[i].want);
        pt_ch.valid <= 1'b0;
        drain();
        // Oversized writes, an unused index and maximum lengths and extreme bases.
        write_reg(appt_pkg::REG_YAW, 32'hFFFFFFFF);
        write_reg(appt_pkg::REG_PITCH, 32'h00014000);
        write_reg(appt_pkg::REG_OUTER, 32'hFFFFFFFF);
        write_reg(appt_pkg::REG_COLUMN, 32'hFFFFFFFF);
        write_reg(appt_pkg::REG_BASE_X, 32'h7FFFFFFF);
        write_reg(appt_pkg::REG_BASE_Y, 32'h80000000);
        write_reg(appt_pkg::REG_BASE_Z, 32'h7FFFFFFF);
        write_reg(REG_UNUSED, 32'h12345678);
        foreach (directed_rows[i])
            send_point(directed_rows[i].px, directed_rows[i].py, directed_rows[i].pz,
                       0, none);
        pt_ch.valid <= 1'b0;
        drain();
        // Quarter-turn boundaries of both angles.
        write_reg(appt_pkg::REG_YAW, 32'h4000);
        write_reg(appt_pkg::REG_PITCH, 32'hC000);
        write_reg(appt_pkg::REG_OUTER, 0);
        write_reg(appt_pkg::REG_COLUMN, 0);
        write_reg(appt_pkg::REG_BASE_X, 32'h80000000);
        write_reg(appt_pkg::REG_BASE_Y, 32'h7FFFFFFF);
        write_reg(appt_pkg::REG_BASE_Z, 32'h80000000);
        for (int i = 0; i < 8; i++)
            send_point(rand_coord(), rand_coord(), rand_coord(), 0, none);
        pt_ch.valid <= 1'b0;
        drain();

        // Random phases; one phase runs without any idling.
        for (int ph = 0; ph < 15; ph++)
        begin
            random_pose();
            steady = (ph == 7);
            for (int i = 0; i < RANDOM_POINTS / 15; i++)
                send_point(rand_coord(), rand_coord(), rand_coord(), 0, none);
            pt_ch.valid <= 1'b0;
            drain();
            steady = 1'b0;
        end

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
